/* src/dlc_pkg.sv */
// Shared types and constants for the direct linear convolution block.
`default_nettype none

package dlc_pkg;

    // Default depth of the tap chain
    localparam int DLC_MAX_TAPS = 32;

    // Field widths
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = SAMPLE_W + COEF_W;
    localparam int ACC_W       = 40;
    localparam int TAP_IDX_W   = 5;
    localparam int TAP_CNT_W   = 6;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 40;

    // Input tdata field positions
    localparam int TAP_IDX_LSB = 0;
    localparam int TAP_VAL_LSB = TAP_IDX_LSB + TAP_IDX_W;
    localparam int SAMPLE_LSB  = TAP_VAL_LSB + COEF_W;

    // Command codes carried on s_tuser
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Per-cycle control handed to every cell of the chain
    typedef struct packed {
        logic shift;
        logic clear;
    } dlc_cell_ctrl_t;

endpackage

`default_nettype wire

/* src/dlc_cell.sv */
// One tap cell: holds a history sample and a coefficient, adds its product to the passing sum.
`default_nettype none

module dlc_cell
    import dlc_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire dlc_cell_ctrl_t              ctrl,
    input  wire logic                        coef_we,
    input  wire logic signed [COEF_W-1:0]    coef_wdata,
    input  wire logic signed [SAMPLE_W-1:0]  sample_in,
    output logic signed [SAMPLE_W-1:0]       sample_out,
    input  wire logic signed [ACC_W-1:0]     sum_in,
    output logic signed [ACC_W-1:0]          sum_out
);

    logic signed [SAMPLE_W-1:0] hist_reg;
    logic signed [COEF_W-1:0]   coef_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    sum_reg;

    // Hold, shift or clear the history sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
        end else if (ctrl.clear) begin
            hist_reg <= '0;
        end else if (ctrl.shift) begin
            hist_reg <= sample_in;
        end
    end

    // Load the coefficient on a tap write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else if (coef_we) begin
            coef_reg <= coef_wdata;
        end
    end

    // Register the product, then add it to the sum coming from the left neighbor
    always_ff @(posedge aclk) begin
        prod_reg <= coef_reg * hist_reg;
        sum_reg  <= sum_in + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    end

    assign sample_out = hist_reg;
    assign sum_out    = sum_reg;

endmodule

`default_nettype wire

/* src/direct_linear_convolution.sv */
// Top level of the direct-form full linear convolution block.
`default_nettype none

// Full linear convolution of a finite signal with up to MAX_TAPS taps, built as
// a row of tap cells. Each cell holds one history sample and one coefficient,
// registers their product, and adds it to a partial sum that moves one cell to
// the right every cycle. A load item (s_tuser = 0) writes one tap. A sample
// item (s_tuser = 1) shifts the sample into the row and produces one output
// once the partial sum has walked through the first taps cells, where taps is
// the tap count in use. An item with s_tlast high then produces taps - 1 tail
// outputs, marks the final one with m_tlast and clears the history. A new item
// is taken once the last output of the current one has moved into the output
// register, so a waiting result does not hold off the next item.

module direct_linear_convolution
    import dlc_pkg::*;
#(
    parameter int MAX_TAPS = DLC_MAX_TAPS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration: tap_count
    input  wire logic                  cfg_wen,
    input  wire logic [TAP_CNT_W-1:0]  cfg_wdata,
    // input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // tap_index[4:0], tap_value[20:5], sample[36:21]
    input  wire logic                  s_tuser,   // command
    input  wire logic                  s_tlast,   // end_of_signal
    // result items
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // conv_value[39:0]
    output logic                       m_tlast    // last
);

    localparam int TW = $clog2(MAX_TAPS + 1);
    localparam int IW = $clog2(MAX_TAPS);
    localparam int CW = $clog2(MAX_TAPS + 2);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_SWEEP = 1'b1;

    logic                   state_reg, state_next;
    logic [TAP_CNT_W-1:0]   tap_count_reg;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [CW-1:0]          done_reg, done_next;
    logic [IW-1:0]          sel_reg, sel_next;
    logic [TW-1:0]          tail_reg, tail_next;
    logic                   eos_reg, eos_next;
    logic                   m_valid_reg;
    logic [ACC_W-1:0]       m_data_reg;
    logic                   m_last_reg;

    logic [TW-1:0]          taps_use;
    logic                   s_accept;
    logic                   is_sample;
    logic                   capture;
    dlc_cell_ctrl_t         cell_ctrl;
    logic signed [SAMPLE_W-1:0] first_sample;
    logic [TAP_IDX_W-1:0]   in_tap_index;
    logic signed [COEF_W-1:0] in_tap_value;

    logic signed [SAMPLE_W-1:0] cell_hist [MAX_TAPS];
    logic signed [ACC_W-1:0]    cell_sum  [MAX_TAPS];
    logic                       coef_we   [MAX_TAPS];

    // Unpack the input fields
    assign in_tap_index = s_tdata[TAP_VAL_LSB-1:TAP_IDX_LSB];
    assign in_tap_value = s_tdata[SAMPLE_LSB-1:TAP_VAL_LSB];
    assign first_sample = (state_reg == ST_IDLE) ? s_tdata[SAMPLE_LSB+SAMPLE_W-1:SAMPLE_LSB]
                                                 : '0;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg <= TAP_CNT_W'(1);
        end else if (cfg_wen) begin
            tap_count_reg <= cfg_wdata;
        end
    end

    // Clamp the tap count to 1..MAX_TAPS
    always_comb begin
        if (tap_count_reg == '0) begin
            taps_use = TW'(1);
        end else if (32'(tap_count_reg) > MAX_TAPS) begin
            taps_use = TW'(MAX_TAPS);
        end else begin
            taps_use = TW'(tap_count_reg);
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign is_sample = (s_tuser == CMD_SAMPLE);
    assign capture   = (state_reg == ST_SWEEP) && (cnt_reg == done_reg)
                       && (!m_valid_reg || m_tready);

    // Shift on a new sample or a tail step; clear after the final output
    assign cell_ctrl.shift = (s_accept && is_sample) || (capture && tail_reg != '0);
    assign cell_ctrl.clear = capture && (tail_reg == '0) && eos_reg;

    // Row of tap cells
    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
        assign coef_we[k] = s_accept && !is_sample && (32'(in_tap_index) == k);

        if (k == 0) begin : g_head
            dlc_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (cell_ctrl),
                .coef_we    (coef_we[k]),
                .coef_wdata (in_tap_value),
                .sample_in  (first_sample),
                .sample_out (cell_hist[k]),
                .sum_in     ({ACC_W{1'b0}}),
                .sum_out    (cell_sum[k])
            );
        end else begin : g_body
            dlc_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (cell_ctrl),
                .coef_we    (coef_we[k]),
                .coef_wdata (in_tap_value),
                .sample_in  (cell_hist[k-1]),
                .sample_out (cell_hist[k]),
                .sum_in     (cell_sum[k-1]),
                .sum_out    (cell_sum[k])
            );
        end
    end

    // Sequencer: wait for the partial sum to reach the last tap in use
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = done_reg;
        sel_next   = sel_reg;
        tail_next  = tail_reg;
        eos_next   = eos_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && is_sample) begin
                    state_next = ST_SWEEP;
                    cnt_next   = '0;
                    done_next  = CW'(taps_use) + CW'(1);
                    sel_next   = IW'(taps_use - TW'(1));
                    eos_next   = s_tlast;
                    tail_next  = s_tlast ? (taps_use - TW'(1)) : '0;
                end
            end
            ST_SWEEP: begin
                if (capture) begin
                    if (tail_reg != '0) begin
                        tail_next = tail_reg - TW'(1);
                        cnt_next  = '0;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else if (cnt_reg != done_reg) begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= '0;
            sel_reg   <= '0;
            tail_reg  <= '0;
            eos_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            sel_reg   <= sel_next;
            tail_reg  <= tail_next;
            eos_reg   <= eos_next;
        end
    end

    // Output register: take the finished sum, drop valid once the item is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (capture) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (capture) begin
            m_data_reg <= cell_sum[sel_reg];
            m_last_reg <= eos_reg && (tail_reg == '0);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire
